[hdl/ptc_pkg.sv]
`default_nettype none

package ptc_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_SENS     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFF      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TCS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TCO      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TREF     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TEMPSENS = 3'd5;

  // stream payload widths
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 28;
  localparam int ZONE_W    = 2;
  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int OUT_DATA_W = 2 * TEMP_W + 2 * PRES_W + ZONE_W;

  // temperature zones
  localparam logic [ZONE_W-1:0] ZONE_HOT  = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_MILD = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_COLD = 2'd2;

  // 20.00 C and 10.00 C in hundredths
  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] TEMP_MILD = 20'sd1000;
  localparam logic signed [63:0] TEMP_BASE = 64'sd2000 * 64'sd8388608;

  // saturation limits
  localparam logic signed [63:0] TEMP_MAX = 64'sd262143;
  localparam logic signed [63:0] TEMP_MIN = -64'sd262144;
  localparam logic signed [63:0] PRES_MAX = 64'sd134217727;
  localparam logic signed [63:0] PRES_MIN = -64'sd134217728;

  // arithmetic shift right that rounds toward zero
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > TEMP_MAX) c = TEMP_MAX;
    if (v < TEMP_MIN) c = TEMP_MIN;
    return c[TEMP_W-1:0];
  endfunction

  function automatic logic signed [PRES_W-1:0] sat_pres(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > PRES_MAX) c = PRES_MAX;
    if (v < PRES_MIN) c = PRES_MIN;
    return c[PRES_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/pressure_temperature_compensation.sv]
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  in_tdata: raw_pressure, raw_temperature
// out_      out  out_tvalid/out_tready out_tdata: temp_first, temp_corrected,
//                                      pressure_first, pressure_corrected, temp_zone
// cfg_      in   cfg_we               cfg_addr, cfg_wdata (coefficient writes)
//
// nine register stages; one transaction accepted per cycle while the output is not stalled
// the depth is set by the two split pressure products (24 x 36 and 24 x 37) and their sums
// rst_n (synchronous) clears the stage valid bits and the coefficients
// a stall at the output freezes every stage; in_tready follows the output stage

module pressure_temperature_compensation (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [ptc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  wire logic [ptc_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // temp_first [18:0], temp_corrected [37:19], pressure_first [65:38],
  // pressure_corrected [93:66], temp_zone [95:94]
  output logic [ptc_pkg::OUT_DATA_W-1:0]           out_tdata
);
  import ptc_pkg::*;

  // coefficient registers
  logic [15:0] coeff_sens_r, coeff_off_r, coeff_tcs_r, coeff_tco_r;
  logic [15:0] coeff_tref_r, coeff_tempsens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_sens_r     <= '0;
      coeff_off_r      <= '0;
      coeff_tcs_r      <= '0;
      coeff_tco_r      <= '0;
      coeff_tref_r     <= '0;
      coeff_tempsens_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SENS:     coeff_sens_r     <= cfg_wdata;
        CFG_OFF:      coeff_off_r      <= cfg_wdata;
        CFG_TCS:      coeff_tcs_r      <= cfg_wdata;
        CFG_TCO:      coeff_tco_r      <= cfg_wdata;
        CFG_TREF:     coeff_tref_r     <= cfg_wdata;
        CFG_TEMPSENS: coeff_tempsens_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: whole pipe moves unless the output holds a waiting result
  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;

  assign adv       = !s9_v_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
      s4_v_r <= 1'b0; s5_v_r <= 1'b0; s6_v_r <= 1'b0;
      s7_v_r <= 1'b0; s8_v_r <= 1'b0; s9_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r; s3_v_r <= s2_v_r; s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r; s6_v_r <= s5_v_r; s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r; s9_v_r <= s8_v_r;
    end
  end

  // stage 1: temperature difference
  logic [RAW_W-1:0]  s1_d1_r;
  logic signed [24:0] s1_dt_r;

  // stage 2: products of the difference
  logic [RAW_W-1:0]   s2_d1_r;
  logic signed [41:0] s2_pt_r, s2_po_r, s2_ps_r;
  logic [47:0]        s2_dsq_r;
  logic signed [49:0] dsq_full;

  assign dsq_full = s1_dt_r * s1_dt_r;

  // stage 3: first-order temperature, offset, sensitivity
  logic signed [63:0] temp_nxt, off_nxt, sens_nxt;
  logic [51:0]        t12_full, t14_full;
  logic [RAW_W-1:0]   s3_d1_r;
  logic signed [19:0] s3_temp_r;
  logic signed [36:0] s3_off_r;
  logic signed [35:0] s3_sens_r;
  logic [16:0]        s3_ti12_r, s3_ti14_r;

  assign temp_nxt = shr_trunc(TEMP_BASE + 64'(s2_pt_r), 23);
  assign off_nxt  = shr_trunc(($signed(64'(coeff_off_r)) <<< 23) + 64'(s2_po_r), 6);
  assign sens_nxt = shr_trunc(($signed(64'(coeff_sens_r)) <<< 23) + 64'(s2_ps_r), 7);
  assign t12_full = 52'(s2_dsq_r) * 52'd12;
  assign t14_full = 52'(s2_dsq_r) * 52'd14;

  // stage 4: zone, square of the temperature offset, first pressure partials
  logic signed [19:0] dtemp_nxt;
  logic signed [39:0] sq_full;
  logic [ZONE_W-1:0]  zone_nxt;
  logic [16:0]        ti_nxt;
  logic [RAW_W-1:0]   s4_d1_r;
  logic signed [19:0] s4_temp_r, s4_temp2_r;
  logic signed [36:0] s4_off_r;
  logic signed [35:0] s4_sens_r;
  logic [34:0]        s4_sq_r;
  logic [ZONE_W-1:0]  s4_zone_r;
  logic [41:0]        s4_pl_r;
  logic signed [42:0] s4_ph_r;

  assign dtemp_nxt = s3_temp_r - TEMP_REF;
  assign sq_full   = dtemp_nxt * dtemp_nxt;

  always_comb begin
    if (s3_temp_r > TEMP_REF) begin
      zone_nxt = ZONE_HOT;
      ti_nxt   = '0;
    end else if (s3_temp_r > TEMP_MILD) begin
      zone_nxt = ZONE_MILD;
      ti_nxt   = s3_ti12_r;
    end else begin
      zone_nxt = ZONE_COLD;
      ti_nxt   = s3_ti14_r;
    end
  end

  // stage 5: second-order offset and sensitivity terms, first pressure sum
  logic [40:0]        m30_full, m35_full, m63_full;
  logic [37:0]        offi_nxt;
  logic [35:0]        sensi_nxt;
  logic signed [63:0] pnum_nxt;
  logic [RAW_W-1:0]   s5_d1_r;
  logic signed [19:0] s5_temp_r, s5_temp2_r;
  logic signed [36:0] s5_off_r;
  logic signed [35:0] s5_sens_r;
  logic [ZONE_W-1:0]  s5_zone_r;
  logic [37:0]        s5_offi_r;
  logic [35:0]        s5_sensi_r;
  logic signed [63:0] s5_pnum_r;

  assign m30_full = 41'(s4_sq_r) * 41'd30;
  assign m35_full = 41'(s4_sq_r) * 41'd35;
  assign m63_full = 41'(s4_sq_r) * 41'd63;

  always_comb begin
    case (s4_zone_r)
      ZONE_MILD: begin
        offi_nxt  = 38'(m30_full[40:8]);
        sensi_nxt = '0;
      end
      ZONE_COLD: begin
        offi_nxt  = m35_full[40:3];
        sensi_nxt = m63_full[40:5];
      end
      default: begin
        offi_nxt  = '0;
        sensi_nxt = '0;
      end
    endcase
  end

  assign pnum_nxt = $signed(64'(s4_pl_r)) + (64'(s4_ph_r) <<< 18)
                    - (64'(s4_off_r) <<< 21);

  // stage 6: corrected offset and sensitivity, first-order pressure
  logic signed [38:0] off2_nxt;
  logic signed [36:0] sens2_nxt;
  logic [RAW_W-1:0]   s6_d1_r;
  logic signed [19:0] s6_temp_r, s6_temp2_r;
  logic [ZONE_W-1:0]  s6_zone_r;
  logic signed [38:0] s6_off2_r;
  logic signed [36:0] s6_sens2_r;
  logic signed [PRES_W-1:0] s6_p_r;

  assign off2_nxt  = 39'(s5_off_r) - $signed({1'b0, s5_offi_r});
  assign sens2_nxt = 37'(s5_sens_r) - $signed({1'b0, s5_sensi_r});

  // stage 7: corrected pressure partials
  logic signed [19:0] s7_temp_r, s7_temp2_r;
  logic [ZONE_W-1:0]  s7_zone_r;
  logic signed [38:0] s7_off2_r;
  logic signed [PRES_W-1:0] s7_p_r;
  logic [42:0]        s7_ql_r;
  logic signed [42:0] s7_qh_r;

  // stage 8: corrected pressure sum
  logic signed [19:0] s8_temp_r, s8_temp2_r;
  logic [ZONE_W-1:0]  s8_zone_r;
  logic signed [PRES_W-1:0] s8_p_r;
  logic signed [63:0] s8_pnum_r;

  // stage 9: output register
  logic signed [TEMP_W-1:0] out_temp1_r, out_temp2_r;
  logic signed [PRES_W-1:0] out_p1_r, out_p2_r;
  logic [ZONE_W-1:0]        out_zone_r;

  // stage payload registers, frozen together on a stall
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d1_r <= in_tdata[RAW_W-1:0];
      s1_dt_r <= $signed({1'b0, in_tdata[IN_DATA_W-1:RAW_W]})
                 - $signed({1'b0, coeff_tref_r, 8'h00});

      s2_d1_r  <= s1_d1_r;
      s2_pt_r  <= s1_dt_r * $signed({1'b0, coeff_tempsens_r});
      s2_po_r  <= s1_dt_r * $signed({1'b0, coeff_tco_r});
      s2_ps_r  <= s1_dt_r * $signed({1'b0, coeff_tcs_r});
      s2_dsq_r <= dsq_full[47:0];

      s3_d1_r   <= s2_d1_r;
      s3_temp_r <= temp_nxt[19:0];
      s3_off_r  <= off_nxt[36:0];
      s3_sens_r <= sens_nxt[35:0];
      s3_ti12_r <= t12_full[51:35];
      s3_ti14_r <= t14_full[51:35];

      s4_d1_r    <= s3_d1_r;
      s4_temp_r  <= s3_temp_r;
      s4_temp2_r <= s3_temp_r - $signed({3'b000, ti_nxt});
      s4_off_r   <= s3_off_r;
      s4_sens_r  <= s3_sens_r;
      s4_sq_r    <= sq_full[34:0];
      s4_zone_r  <= zone_nxt;
      s4_pl_r    <= s3_d1_r * s3_sens_r[17:0];
      s4_ph_r    <= $signed({1'b0, s3_d1_r}) * $signed(s3_sens_r[35:18]);

      s5_d1_r    <= s4_d1_r;
      s5_temp_r  <= s4_temp_r;
      s5_temp2_r <= s4_temp2_r;
      s5_off_r   <= s4_off_r;
      s5_sens_r  <= s4_sens_r;
      s5_zone_r  <= s4_zone_r;
      s5_offi_r  <= offi_nxt;
      s5_sensi_r <= sensi_nxt;
      s5_pnum_r  <= pnum_nxt;

      s6_d1_r    <= s5_d1_r;
      s6_temp_r  <= s5_temp_r;
      s6_temp2_r <= s5_temp2_r;
      s6_zone_r  <= s5_zone_r;
      s6_off2_r  <= off2_nxt;
      s6_sens2_r <= sens2_nxt;
      s6_p_r     <= sat_pres(shr_trunc(s5_pnum_r, 36));

      s7_temp_r  <= s6_temp_r;
      s7_temp2_r <= s6_temp2_r;
      s7_zone_r  <= s6_zone_r;
      s7_off2_r  <= s6_off2_r;
      s7_p_r     <= s6_p_r;
      s7_ql_r    <= s6_d1_r * s6_sens2_r[18:0];
      s7_qh_r    <= $signed({1'b0, s6_d1_r}) * $signed(s6_sens2_r[36:19]);

      s8_temp_r  <= s7_temp_r;
      s8_temp2_r <= s7_temp2_r;
      s8_zone_r  <= s7_zone_r;
      s8_p_r     <= s7_p_r;
      s8_pnum_r  <= $signed(64'(s7_ql_r)) + (64'(s7_qh_r) <<< 19)
                    - (64'(s7_off2_r) <<< 21);

      out_temp1_r <= sat_temp(64'(s8_temp_r));
      out_temp2_r <= sat_temp(64'(s8_temp2_r));
      out_p1_r    <= s8_p_r;
      out_p2_r    <= sat_pres(shr_trunc(s8_pnum_r, 36));
      out_zone_r  <= s8_zone_r;
    end
  end

  assign out_tvalid = s9_v_r;
  assign out_tdata  = {out_zone_r, out_p2_r, out_p1_r, out_temp2_r, out_temp1_r};

  // checks on the result stage
  a_hot_no_temp_corr: assert property (@(posedge clk) disable iff (!rst_n)
    (s9_v_r && out_zone_r == ZONE_HOT) |-> (out_temp2_r == out_temp1_r))
    else $error("hot zone result carries a temperature correction");

  a_corr_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    s9_v_r |-> (out_temp2_r <= out_temp1_r))
    else $error("corrected temperature above first-order temperature");

  a_cold_zone_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (s9_v_r && out_zone_r == ZONE_COLD) |-> (out_temp1_r <= 19'sd1000))
    else $error("cold zone with first-order temperature above 10 C");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_v_r)
    else $error("accepted transaction missing from first stage");

endmodule

`default_nettype wire
